// ===== sv/waypoint_follower_p_control_macros.svh =====
// Assertion helpers for the waypoint follower.
`ifndef WAYPOINT_FOLLOWER_P_CONTROL_MACROS_SVH
`define WAYPOINT_FOLLOWER_P_CONTROL_MACROS_SVH

// Implication checked on every clock, masked during reset.
`define WPF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define WPF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/wpf_pkg.sv =====
`default_nettype none
package wpf_pkg;

  localparam int unsigned CordicSteps = 16;
  localparam logic signed [19:0] HalfPiQ16 = 20'sd102944;
  localparam logic signed [15:0] PiQ12 = 16'sd12868;
  localparam logic signed [16:0] TwoPiQ12 = 17'sd25736;
  localparam logic [63:0] DeadbandRaw = 64'd65;
  localparam logic [31:0] LinOffset = 32'd655;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_POSE = 1'b1;

  localparam logic [1:0] REG_LIN_GAIN = 2'd0;
  localparam logic [1:0] REG_ANG_GAIN = 2'd1;
  localparam logic [1:0] REG_STATIC = 2'd2;
  localparam logic [1:0] REG_THRESH = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_DIFF,
    ST_SQUARE,
    ST_SQRT,
    ST_CMP,
    ST_CORDIC,
    ST_ERR,
    ST_MUL,
    ST_SAT,
    ST_OUT
  } wpf_state_t;

  function automatic logic signed [19:0] atan_q16(input logic [3:0] i);
    logic signed [19:0] v;
    begin
      case (i)
        4'd0: v = 20'sd51472;
        4'd1: v = 20'sd30386;
        4'd2: v = 20'sd16055;
        4'd3: v = 20'sd8150;
        4'd4: v = 20'sd4091;
        4'd5: v = 20'sd2047;
        4'd6: v = 20'sd1024;
        4'd7: v = 20'sd512;
        4'd8: v = 20'sd256;
        4'd9: v = 20'sd128;
        4'd10: v = 20'sd64;
        4'd11: v = 20'sd32;
        4'd12: v = 20'sd16;
        4'd13: v = 20'sd8;
        4'd14: v = 20'sd4;
        default: v = 20'sd2;
      endcase
      return v;
    end
  endfunction

endpackage
`default_nettype wire

// ===== sv/wpf_sqrt.sv =====
`default_nettype none
// Bit-pair restoring square root, one result bit per cycle.
module wpf_sqrt import wpf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] radicand,
  output logic             done,
  output logic [31:0]      root
);
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] res_r, res_nxt;
  logic [63:0] bit_r, bit_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;

  always_comb begin
    rem_nxt = rem_r;
    res_nxt = res_r;
    bit_nxt = bit_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = radicand;
      res_nxt = '0;
      bit_nxt = 64'h4000_0000_0000_0000;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_r >= res_r + bit_r) begin
        rem_nxt = rem_r - (res_r + bit_r);
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r == 64'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

  assign done = done_r;
  assign root = res_r[31:0];
endmodule
`default_nettype wire

// ===== sv/wpf_cordic.sv =====
`default_nettype none
// Vectoring CORDIC, one micro-rotation per cycle; bearing in Q3.12.
module wpf_cordic import wpf_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [32:0] vx,
  input  wire logic signed [32:0] vy,
  output logic                    done,
  output logic signed [15:0]      bearing
);
  logic signed [35:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [20:0] z_r, z_nxt;
  logic [3:0]         i_r, i_nxt;
  logic               busy_r, busy_nxt, done_r, done_nxt;
  logic signed [35:0] sx, sy;
  logic signed [20:0] zr;

  assign sx = x_r >>> i_r;
  assign sy = y_r >>> i_r;

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    i_nxt = i_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      i_nxt = '0;
      busy_nxt = 1'b1;
      if (vx < 0) begin
        if (vy >= 0) begin
          x_nxt = 36'(vy);
          y_nxt = -36'(vx);
          z_nxt = 21'(HalfPiQ16);
        end else begin
          x_nxt = -36'(vy);
          y_nxt = 36'(vx);
          z_nxt = -21'(HalfPiQ16);
        end
      end else begin
        x_nxt = 36'(vx);
        y_nxt = 36'(vy);
        z_nxt = '0;
      end
    end else if (busy_r) begin
      if (y_r >= 0) begin
        x_nxt = x_r + sy;
        y_nxt = y_r - sx;
        z_nxt = z_r + 21'(atan_q16(i_r));
      end else begin
        x_nxt = x_r - sy;
        y_nxt = y_r + sx;
        z_nxt = z_r - 21'(atan_q16(i_r));
      end
      i_nxt = i_r + 4'd1;
      if (i_r == 4'(CordicSteps - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    i_r <= i_nxt;
  end

  assign zr = (z_r + 21'sd8) >>> 4;
  assign done = done_r;
  assign bearing = zr[15:0];
endmodule
`default_nettype wire

// ===== sv/waypoint_follower_p_control.sv =====
`default_nettype none
// Channel | Dir | Handshake            | Payload
// in_     | in  | in_valid/in_stall    | op, pos_x, pos_y, heading
// out_    | out | out_valid/out_stall  | command_valid, velocities, index, goal, count
// cfg_    | in  | APB psel/penable     | four registers at 4*i
//
// Load beat, or pose with an empty table: the sequencer goes from ST_READ
// straight to ST_OUT. Pose beat: the result is set by the 32-step square root
// followed by the 16-step CORDIC, both serial units; the CORDIC is skipped on
// arrival. Reset is synchronous and clears counters and control; the waypoint
// table is not cleared. A stalled result holds in the output register; the
// next input beat is taken only when the sequencer is idle and that register
// is free.
module waypoint_follower_p_control import wpf_pkg::*; #(
  parameter int unsigned MAX_WAYPOINTS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_op,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic signed [15:0] in_heading,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_command_valid,
  output logic signed [31:0]      out_linear_velocity,
  output logic signed [31:0]      out_angular_velocity,
  output logic [5:0]              out_waypoint_index,
  output logic                    out_goal_reached,
  output logic [6:0]              out_loaded_count,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  `include "waypoint_follower_p_control_macros.svh"

  localparam int unsigned AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_WAYPOINTS + 1);

  // Config registers
  logic [15:0] lin_gain_r, ang_gain_r, static_r;
  logic [30:0] thresh_r;
  logic        cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lin_gain_r <= 16'd256;
      ang_gain_r <= 16'd256;
      static_r <= 16'd0;
      thresh_r <= 31'd6554;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_LIN_GAIN: lin_gain_r <= pwdata[15:0];
        REG_ANG_GAIN: ang_gain_r <= pwdata[15:0];
        REG_STATIC:   static_r <= pwdata[15:0];
        REG_THRESH:   thresh_r <= pwdata[30:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_LIN_GAIN: prdata = {16'd0, lin_gain_r};
      REG_ANG_GAIN: prdata = {16'd0, ang_gain_r};
      REG_STATIC:   prdata = {16'd0, static_r};
      REG_THRESH:   prdata = {1'b0, thresh_r};
      default:      prdata = '0;
    endcase
  end

  // Sequencer state
  wpf_state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] tgt_r, tgt_nxt;
  logic          goal_r, goal_nxt;

  logic               in_op_r;
  logic signed [31:0] in_pos_x_r, in_pos_y_r;
  logic signed [15:0] in_heading_r;
  logic signed [32:0] dx_r, dy_r;
  logic               sh_r;
  logic [32:0]        dist_r;
  logic signed [16:0] err_r;
  logic [48:0]        lin_prod_r;
  logic signed [33:0] ang_prod_r;

  logic        ov_r;
  logic        ocv_r;
  logic signed [31:0] olin_r, oang_r;

  // Waypoint table: one synchronous memory, {x, y} per entry.
  logic [63:0] wp_mem [MAX_WAYPOINTS];
  logic [63:0] wp_rd_r;
  logic        wp_we;
  logic [AW-1:0] wp_waddr, wp_raddr;

  always_ff @(posedge clk) begin
    if (wp_we) wp_mem[wp_waddr] <= {in_pos_x_r, in_pos_y_r};
    wp_rd_r <= wp_mem[wp_raddr];
  end

  logic in_acc, out_acc;
  assign in_stall = (state_r != ST_IDLE) || ov_r;
  assign in_acc = in_valid && !in_stall;
  assign out_acc = ov_r && !out_stall;

  // Combinational datapath pieces
  logic [32:0] ax, ay;
  logic        need_sh;
  logic [32:0] axs, ays;
  logic [63:0] sq_val;
  logic signed [17:0] e0;
  logic signed [17:0] e1;
  logic               table_full;

  // Math units
  logic               sq_start, sq_done, cd_start, cd_done;
  logic [31:0]        root;
  logic signed [15:0] bearing;

  // Squares feed the root unit directly in ST_SQUARE, the cycle it starts.
  wpf_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(sq_val),
    .done(sq_done), .root(root)
  );

  wpf_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cd_start), .vx(dx_r), .vy(dy_r),
    .done(cd_done), .bearing(bearing)
  );

  assign ax = dx_r[32] ? 33'(-dx_r) : 33'(dx_r);
  assign ay = dy_r[32] ? 33'(-dy_r) : 33'(dy_r);
  assign need_sh = ax[32] || ax[31] || ay[32] || ay[31];
  assign axs = need_sh ? (ax >> 1) : ax;
  assign ays = need_sh ? (ay >> 1) : ay;
  assign sq_val = 64'(axs[31:0]) * 64'(axs[31:0]) + 64'(ays[31:0]) * 64'(ays[31:0]);
  assign table_full = (count_r == CW'(MAX_WAYPOINTS));
  assign e0 = 18'(bearing) - 18'(in_heading_r);
  // At most two wrap steps: |bearing - heading| stays below 4*pi.
  always_comb begin
    if (e0 > 18'(PiQ12) + 18'(TwoPiQ12)) e1 = e0 - 18'(TwoPiQ12) - 18'(TwoPiQ12);
    else if (e0 > 18'(PiQ12)) e1 = e0 - 18'(TwoPiQ12);
    else if (e0 < -18'(PiQ12) - 18'(TwoPiQ12)) e1 = e0 + 18'(TwoPiQ12) + 18'(TwoPiQ12);
    else if (e0 < -18'(PiQ12)) e1 = e0 + 18'(TwoPiQ12);
    else e1 = e0;
  end

  logic [AW-1:0] tgt_safe;
  assign tgt_safe = tgt_r;
  assign wp_raddr = tgt_safe;
  assign wp_waddr = count_r[AW-1:0];

  // Next-state logic
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_acc) state_nxt = ST_READ;
      ST_READ: begin
        if (in_op_r == OP_LOAD || count_r == '0) state_nxt = ST_OUT;
        else state_nxt = ST_DIFF;
      end
      ST_DIFF:   state_nxt = ST_SQUARE;
      ST_SQUARE: state_nxt = ST_SQRT;
      ST_SQRT:   if (sq_done) state_nxt = ST_CMP;
      ST_CMP:    state_nxt = (dist_r > 33'(thresh_r)) ? ST_CORDIC : ST_OUT;
      ST_CORDIC: if (cd_done) state_nxt = ST_ERR;
      ST_ERR:    state_nxt = ST_MUL;
      ST_MUL:    state_nxt = ST_SAT;
      ST_SAT:    state_nxt = ST_OUT;
      ST_OUT:    state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Output / control logic
  always_comb begin
    count_nxt = count_r;
    tgt_nxt = tgt_r;
    goal_nxt = goal_r;
    wp_we = 1'b0;
    sq_start = (state_r == ST_SQUARE);
    cd_start = (state_r == ST_CMP) && (dist_r > 33'(thresh_r));
    if (state_r == ST_READ && in_op_r == OP_LOAD && !table_full) begin
      wp_we = 1'b1;
      count_nxt = count_r + CW'(1);
    end
    if (state_r == ST_CMP && !(dist_r > 33'(thresh_r))) begin
      if (CW'(tgt_r) + CW'(1) < count_r) tgt_nxt = tgt_r + AW'(1);
      else goal_nxt = 1'b1;
    end
  end

  logic signed [63:0] lin_full;
  logic signed [34:0] ang_full;
  assign lin_full = (dist_r > 33'(DeadbandRaw)) ?
                    (64'(lin_prod_r >> 8) + 64'(LinOffset)) : 64'sd0;
  assign ang_full = 35'(ang_prod_r >>> 4) +
                    ((err_r > 0) ? 35'({static_r, 8'd0}) :
                     (err_r < 0) ? -35'({static_r, 8'd0}) : 35'sd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      tgt_r <= '0;
      goal_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      tgt_r <= tgt_nxt;
      goal_r <= goal_nxt;
      if (state_r == ST_OUT) ov_r <= 1'b1;
      else if (out_acc) ov_r <= 1'b0;
    end
    if (in_acc) begin
      in_op_r <= in_op;
      in_pos_x_r <= in_pos_x;
      in_pos_y_r <= in_pos_y;
      in_heading_r <= in_heading;
      ocv_r <= 1'b0;
      olin_r <= '0;
      oang_r <= '0;
    end
    if (state_r == ST_DIFF) begin
      dx_r <= 33'($signed(wp_rd_r[63:32])) - 33'(in_pos_x_r);
      dy_r <= 33'($signed(wp_rd_r[31:0])) - 33'(in_pos_y_r);
    end
    if (state_r == ST_SQUARE) sh_r <= need_sh;
    if (sq_done) dist_r <= sh_r ? {root, 1'b0} : {1'b0, root};
    if (state_r == ST_CMP) lin_prod_r <= 49'(dist_r) * 49'(lin_gain_r);
    if (state_r == ST_ERR) err_r <= e1[16:0];
    if (state_r == ST_MUL) ang_prod_r <= err_r * $signed({1'b0, ang_gain_r});
    if (state_r == ST_SAT) begin
      ocv_r <= 1'b1;
      olin_r <= (lin_full > 64'sh7FFF_FFFF) ? 32'sh7FFF_FFFF : lin_full[31:0];
      if (ang_full > 35'sh7FFF_FFFF) oang_r <= 32'sh7FFF_FFFF;
      else if (ang_full < -35'sh8000_0000) oang_r <= 32'sh8000_0000;
      else oang_r <= ang_full[31:0];
    end
  end

  assign out_valid = ov_r;
  assign out_command_valid = ocv_r;
  assign out_linear_velocity = olin_r;
  assign out_angular_velocity = oang_r;
  assign out_waypoint_index = 6'(tgt_r);
  assign out_goal_reached = goal_r;
  assign out_loaded_count = 7'(count_r);

  `WPF_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, state_r != ST_IDLE, !in_acc, "accept while busy")
  `WPF_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(MAX_WAYPOINTS), "count overflow")
  `WPF_ASSERT_NEXT(a_goal_sticky, clk, rst_n, goal_r, goal_r, "goal flag dropped")
  `WPF_ASSERT_IMPL(a_tgt_bound, clk, rst_n, count_r != '0, CW'(tgt_r) < count_r, "target beyond table")
endmodule
`default_nettype wire
